[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define SKF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// same-cycle implication
`define SKF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/skf_pkg.sv]
// ----------------------------------------------------------------------------
// skf_pkg
// Widths, reset constants, microcode format and control ROM of the scalar
// Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    // fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int GAIN_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = GAIN_BITS + 1;
    localparam int CFG_IDX_W = 8;

    // divider: one quotient bit per step
    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int NUM_W     = DATA_W + GAIN_BITS + 1;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(64'd1 << GAIN_BITS);

    // register reset values
    localparam logic [DATA_W-1:0] FX_ONE   = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] FX_TENTH = DATA_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE,
        REG_MEAS_NOISE,
        REG_INIT_ERROR,
        REG_INIT_ESTIMATE
    } cfg_reg_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_P1,
        OP_DEN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_GAIN,
        OP_MUL_X,
        OP_UPD_X,
        OP_MUL_P,
        OP_UPD_P,
        OP_EMIT,
        OP_NOP
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DEN_ZERO,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE = step_t'(0);
    localparam step_t S_P1   = step_t'(1);
    localparam step_t S_DEN  = step_t'(2);
    localparam step_t S_DIVI = step_t'(3);
    localparam step_t S_DIVS = step_t'(4);
    localparam step_t S_GAIN = step_t'(5);
    localparam step_t S_MULX = step_t'(6);
    localparam step_t S_UPDX = step_t'(7);
    localparam step_t S_MULP = step_t'(8);
    localparam step_t S_UPDP = step_t'(9);
    localparam step_t S_EMIT = step_t'(10);
    localparam step_t S_DONE = step_t'(11);

    // one control word: operation, jump condition, jump target
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic den_zero;
        logic div_more;
        logic out_busy;
    } skf_status_t;

    // control program
    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        case (s)
            S_IDLE:  w = '{op: OP_IDLE,     cond: C_NO_INPUT, target: S_IDLE};
            S_P1:    w = '{op: OP_P1,       cond: C_NEVER,    target: S_IDLE};
            S_DEN:   w = '{op: OP_DEN,      cond: C_NEVER,    target: S_IDLE};
            S_DIVI:  w = '{op: OP_DIV_INIT, cond: C_DEN_ZERO, target: S_GAIN};
            S_DIVS:  w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: S_DIVS};
            S_GAIN:  w = '{op: OP_GAIN,     cond: C_NEVER,    target: S_IDLE};
            S_MULX:  w = '{op: OP_MUL_X,    cond: C_NEVER,    target: S_IDLE};
            S_UPDX:  w = '{op: OP_UPD_X,    cond: C_NEVER,    target: S_IDLE};
            S_MULP:  w = '{op: OP_MUL_P,    cond: C_NEVER,    target: S_IDLE};
            S_UPDP:  w = '{op: OP_UPD_P,    cond: C_NEVER,    target: S_IDLE};
            S_EMIT:  w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: S_EMIT};
            S_DONE:  w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_IDLE};
            default: w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

[src/skf_if.sv]
// ----------------------------------------------------------------------------
// skf channel interfaces
// Valid/ready channels for configuration writes, measurements and results.
// ----------------------------------------------------------------------------

// configuration write channel
interface skf_cfg_if import skf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// measurement channel
interface skf_in_if import skf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] measured_value;

    modport source (output valid, measured_value, input ready);
    modport sink   (input valid, measured_value, output ready);
endinterface

// result channel
interface skf_out_if import skf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] filtered_estimate;
    logic        [GAIN_W-1:0] kalman_gain;
    logic        [DATA_W-1:0] error_variance;

    modport source (output valid, filtered_estimate, kalman_gain, error_variance,
                    input ready);
    modport sink   (input valid, filtered_estimate, kalman_gain, error_variance,
                    output ready);
endinterface

[src/skf_seq.sv]
// ----------------------------------------------------------------------------
// skf_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module skf_seq import skf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  skf_status_t status,
    output ucode_t      ctrl
);

    step_t  pc_reg;
    step_t  pc_next;
    logic   take;

    assign ctrl = ucode_rom(pc_reg);

    // jump condition
    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_INPUT: take = !status.in_valid;
            C_DEN_ZERO: take = status.den_zero;
            C_DIV_MORE: take = status.div_more;
            C_OUT_BUSY: take = status.out_busy;
            default:    take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : step_t'(pc_reg + step_t'(1));
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[src/scalar_kalman_filter.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter in Q16.16, run by a microcoded datapath.
// ----------------------------------------------------------------------------
// Usage:
//   cfg         : register writes (index 0 Q, 1 R, 2 initial error, 3 initial
//                 estimate); always ready. Writing index 2 or 3 also reloads
//                 the variance or the estimate. Other indexes are ignored.
//   measurement : one measured_value per item, taken only in the idle step.
//   result      : filtered_estimate, kalman_gain (Q1.16) and error_variance,
//                 held in an output register until taken.
// Sequence: after the measurement is accepted, the ROM steps through P1, the
//   denominator P1 + R, the 17-step restoring divider that forms the gain
//   (skipped when P1 + R is zero), the estimate and variance updates on one
//   shared 33x18 multiplier used twice, and the emit step. A new item is
//   accepted only back in the idle step, after the previous one is emitted.
// Reset: the sequencer returns to idle, the output register empties and the
//   registers and state take their default values.
// Stall: while a result waits, the next item is still processed; the emit
//   step holds until the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scalar_kalman_filter import skf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    skf_cfg_if.sink   cfg,
    skf_in_if.sink    measurement,
    skf_out_if.source result
);

    ucode_t      ctrl;
    skf_status_t status;

    // configuration and filter state
    logic        [DATA_W-1:0] q_noise_reg, q_noise_next;
    logic        [DATA_W-1:0] r_noise_reg, r_noise_next;
    logic        [DATA_W-1:0] init_err_reg, init_err_next;
    logic        [DATA_W-1:0] init_est_reg, init_est_next;
    logic signed [DATA_W-1:0] est_reg, est_next;
    logic        [DATA_W-1:0] var_reg, var_next;

    // working registers
    logic signed [DATA_W-1:0] z_reg, z_next;
    logic        [DATA_W-1:0] p1_reg, p1_next;
    logic        [DATA_W:0]   den_reg, den_next;
    logic        [DATA_W:0]   rem_reg, rem_next;
    logic        [GAIN_W-1:0] low_reg, low_next;
    logic        [GAIN_W-1:0] quo_reg, quo_next;
    logic        [CNT_W-1:0]  cnt_reg, cnt_next;
    logic        [GAIN_W-1:0] k_reg, k_next;
    logic signed [DATA_W:0]   diff_reg, diff_next;
    logic signed [DATA_W+GAIN_W+1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] xn_reg, xn_next;
    logic        [DATA_W-1:0] pn_reg, pn_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_est_reg, out_est_next;
    logic        [GAIN_W-1:0] out_gain_reg, out_gain_next;
    logic        [DATA_W-1:0] out_var_reg, out_var_next;

    // combinational datapath
    logic        [DATA_W:0]   p1_sum;
    logic        [NUM_W-1:0]  num;
    logic        [DATA_W+1:0] trial;
    logic                     trial_ge;
    logic signed [DATA_W:0]   mul_a;
    logic signed [GAIN_W:0]   mul_b;
    logic signed [DATA_W+GAIN_W+1:0] rnd_full;
    logic signed [DATA_W+2:0] rnd;
    logic signed [DATA_W+2:0] x_sum;
    logic                     emit_load;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    skf_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // handshakes and sequencer flags
    assign cfg.ready         = 1'b1;
    assign measurement.ready = (ctrl.op == OP_IDLE);

    assign status.in_valid = measurement.valid;
    assign status.den_zero = (den_reg == '0);
    assign status.div_more = (cnt_reg != DIV_LAST);
    assign status.out_busy = out_valid_reg && !result.ready;

    assign emit_load = (ctrl.op == OP_EMIT) && !status.out_busy;

    // arithmetic shared by the steps
    always_comb
    begin
        p1_sum   = {1'b0, var_reg} + {1'b0, q_noise_reg};
        num      = {1'b0, p1_reg, {GAIN_BITS{1'b0}}} + NUM_W'(den_reg[DATA_W:1]);
        trial    = {rem_reg, low_reg[GAIN_W-1]};
        trial_ge = (trial >= {1'b0, den_reg});

        if (ctrl.op == OP_MUL_P)
        begin
            mul_a = $signed({1'b0, p1_reg});
            mul_b = $signed({1'b0, GAIN_W'(GAIN_ONE - k_reg)});
        end
        else
        begin
            mul_a = diff_reg;
            mul_b = $signed({1'b0, k_reg});
        end

        rnd_full = (prod_reg + $signed((DATA_W + GAIN_W + 2)'(64'd1 << (GAIN_BITS - 1))))
                   >>> GAIN_BITS;
        rnd      = rnd_full[DATA_W+2:0];
        x_sum    = {{3{est_reg[DATA_W-1]}}, est_reg} + rnd;
    end

    // next-state logic for all registers
    always_comb
    begin
        q_noise_next   = q_noise_reg;
        r_noise_next   = r_noise_reg;
        init_err_next  = init_err_reg;
        init_est_next  = init_est_reg;
        est_next       = est_reg;
        var_next       = var_reg;
        z_next         = z_reg;
        p1_next        = p1_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        xn_next        = xn_reg;
        pn_next        = pn_reg;
        out_est_next   = out_est_reg;
        out_gain_next  = out_gain_reg;
        out_var_next   = out_var_reg;
        out_valid_next = out_valid_reg && !result.ready;

        // register writes; initial values also reload the state
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_PROCESS_NOISE: q_noise_next = cfg.data;
                REG_MEAS_NOISE:    r_noise_next = cfg.data;
                REG_INIT_ERROR:
                begin
                    init_err_next = cfg.data;
                    var_next      = cfg.data;
                end
                REG_INIT_ESTIMATE:
                begin
                    init_est_next = cfg.data;
                    est_next      = $signed(cfg.data);
                end
                default: ;
            endcase
        end

        case (ctrl.op)
            OP_IDLE:
            begin
                if (measurement.valid)
                begin
                    z_next = measurement.measured_value;
                end
            end
            // predicted variance, saturated
            OP_P1:
            begin
                p1_next = p1_sum[DATA_W] ? '1 : p1_sum[DATA_W-1:0];
            end
            OP_DEN:
            begin
                den_next = {1'b0, p1_reg} + {1'b0, r_noise_reg};
            end
            // rounded numerator loaded into the divider
            OP_DIV_INIT:
            begin
                rem_next = {1'b0, num[NUM_W-1 -: DATA_W]};
                low_next = num[GAIN_W-1:0];
                quo_next = '0;
                cnt_next = '0;
            end
            // one restoring division step; the remainder may need all 33 bits
            OP_DIV_STEP:
            begin
                rem_next = trial_ge ? (DATA_W + 1)'(trial - {1'b0, den_reg})
                                    : trial[DATA_W:0];
                low_next = {low_reg[GAIN_W-2:0], 1'b0};
                quo_next = {quo_reg[GAIN_W-2:0], trial_ge};
                cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
            end
            OP_GAIN:
            begin
                k_next    = (quo_reg > GAIN_ONE) ? GAIN_ONE : quo_reg;
                diff_next = {z_reg[DATA_W-1], z_reg} - {est_reg[DATA_W-1], est_reg};
            end
            OP_MUL_X,
            OP_MUL_P:
            begin
                prod_next = mul_a * mul_b;
            end
            // estimate update, saturated to the signed range
            OP_UPD_X:
            begin
                if (x_sum[DATA_W+2:DATA_W-1] == '0 || x_sum[DATA_W+2:DATA_W-1] == '1)
                begin
                    xn_next = x_sum[DATA_W-1:0];
                end
                else if (x_sum[DATA_W+2])
                begin
                    xn_next = {1'b1, {(DATA_W-1){1'b0}}};
                end
                else
                begin
                    xn_next = {1'b0, {(DATA_W-1){1'b1}}};
                end
            end
            OP_UPD_P:
            begin
                pn_next = (rnd[DATA_W+2:DATA_W] != '0) ? '1 : rnd[DATA_W-1:0];
            end
            OP_EMIT:
            begin
                if (emit_load)
                begin
                    est_next       = xn_reg;
                    var_next       = pn_reg;
                    out_est_next   = xn_reg;
                    out_gain_next  = k_reg;
                    out_var_next   = pn_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control, configuration and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_noise_reg   <= FX_TENTH;
            r_noise_reg   <= FX_TENTH;
            init_err_reg  <= FX_ONE;
            init_est_reg  <= FX_TENTH;
            est_reg       <= $signed(FX_TENTH);
            var_reg       <= FX_ONE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            q_noise_reg   <= q_noise_next;
            r_noise_reg   <= r_noise_next;
            init_err_reg  <= init_err_next;
            init_est_reg  <= init_est_next;
            est_reg       <= est_next;
            var_reg       <= var_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        z_reg        <= z_next;
        p1_reg       <= p1_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        quo_reg      <= quo_next;
        k_reg        <= k_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        xn_reg       <= xn_next;
        pn_reg       <= pn_next;
        out_est_reg  <= out_est_next;
        out_gain_reg <= out_gain_next;
        out_var_reg  <= out_var_next;
    end

    assign result.valid             = out_valid_reg;
    assign result.filtered_estimate = out_est_reg;
    assign result.kalman_gain       = out_gain_reg;
    assign result.error_variance    = out_var_reg;

    // checks
    `SKF_ASSERT_IMPL(a_rem_below_div, ctrl.op == OP_DIV_STEP, rem_reg < den_reg,
        "divider remainder not below divisor")
    `SKF_ASSERT_IMPL(a_result_is_state, result.valid,
        result.error_variance == var_reg && result.filtered_estimate == est_reg,
        "pending result differs from filter state")
    `SKF_ASSERT_NEXT(a_emit_loads_output, emit_load,
        result.valid && result.kalman_gain == $past(k_reg),
        "emit step did not load the output register")
    `SKF_ASSERT(a_valid_from_emit, $rose(result.valid) |-> $past(ctrl.op == OP_EMIT),
        "result raised outside the emit step")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter testbench
// Drives register writes and measurements over valid/ready channels,
// predicts each filter step (gain, estimate, variance) in fixed point and
// checks every result against the oldest prediction. Directed corner items
// come first, then phases of random settings and measurements, with random
// idle bursts on both sides except in the last phase.
// ----------------------------------------------------------------------------
module testbench;
    import skf_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 75;
    localparam int REPORT_LIMIT   = 10;
    localparam int REG_IDX_TOP    = (1 << CFG_IDX_W) - 1;

    localparam logic [DATA_W-1:0]  EST_POS_END = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  EST_NEG_END = 32'h8000_0000;
    localparam logic signed [63:0] EST_HI      = 64'sd2147483647;
    localparam logic signed [63:0] EST_LO      = -64'sd2147483648;
    localparam logic [63:0]        VAR_HI      = 64'hFFFF_FFFF;
    localparam logic [63:0]        ROUND_HALF  = 64'd1 << (GAIN_BITS - 1);

    // kinds of pending stimulus
    typedef enum logic [1:0] {
        ACT_MEAS,
        ACT_WRITE,
        ACT_DRAIN
    } act_kind_t;

    typedef struct {
        act_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    value;
        bit                   calm;
    } stim_act_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] est;
        logic        [GAIN_W-1:0] gain;
        logic        [DATA_W-1:0] err_var;
    } filter_out_t;

    logic clk = 1'b0;
    logic rst_n;

    skf_cfg_if cfg_ch ();
    skf_in_if  meas_ch ();
    skf_out_if res_ch ();

    scalar_kalman_filter i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .measurement (meas_ch),
        .result      (res_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // pending stimulus and predicted filter outputs
    stim_act_t   stim_q[$];
    filter_out_t outputs_due[$];

    // predicted filter registers and state
    logic        [DATA_W-1:0] q_noise;
    logic        [DATA_W-1:0] r_noise;
    logic signed [DATA_W-1:0] est_state;
    logic        [DATA_W-1:0] var_state;

    int  sent_count;
    int  taken_count;
    int  fail_count = 0;
    int  gap_left;
    int  stall_left;
    bit  quiet;
    bit  calm_mode = 1'b0;

    // register write as the filter sees it
    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        case (idx)
            REG_PROCESS_NOISE: q_noise   = val;
            REG_MEAS_NOISE:    r_noise   = val;
            REG_INIT_ERROR:    var_state = val;
            REG_INIT_ESTIMATE: est_state = val;
            default: ;
        endcase
    endfunction

    // one predict/update step; queues the expected output
    function automatic void filter_step(logic signed [DATA_W-1:0] z);
        logic        [63:0] p1;
        logic        [63:0] den;
        logic        [63:0] k;
        logic        [63:0] pn;
        logic signed [63:0] zl;
        logic signed [63:0] xl;
        logic signed [63:0] diff;
        logic signed [63:0] xn;
        filter_out_t        r;
        p1 = 64'(var_state) + 64'(q_noise);
        if (p1 > VAR_HI)
            p1 = VAR_HI;
        den = p1 + 64'(r_noise);
        if (den == 64'd0)
            k = 64'd0;
        else
            k = ((p1 << GAIN_BITS) + (den >> 1)) / den;
        if (k > 64'(GAIN_ONE))
            k = 64'(GAIN_ONE);
        zl   = 64'(z);
        xl   = 64'(est_state);
        diff = zl - xl;
        // product rounded half toward plus infinity
        xn = xl + ((diff * $signed(k) + $signed(ROUND_HALF)) >>> GAIN_BITS);
        if (xn > EST_HI)
            xn = EST_HI;
        if (xn < EST_LO)
            xn = EST_LO;
        pn = (p1 * (64'(GAIN_ONE) - k) + ROUND_HALF) >> GAIN_BITS;
        if (pn > VAR_HI)
            pn = VAR_HI;
        est_state = xn[DATA_W-1:0];
        var_state = pn[DATA_W-1:0];
        r.est     = est_state;
        r.gain    = k[GAIN_W-1:0];
        r.err_var = var_state;
        outputs_due.push_back(r);
    endfunction

    // stimulus queue helpers
    function automatic void add_act(act_kind_t kind, logic [CFG_IDX_W-1:0] idx,
                                    logic [DATA_W-1:0] val);
        stim_act_t a;
        a.kind  = kind;
        a.index = idx;
        a.value = val;
        a.calm  = calm_mode;
        stim_q.push_back(a);
    endfunction

    function automatic void add_meas(logic [DATA_W-1:0] val);
        add_act(ACT_MEAS, '0, val);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        add_act(ACT_WRITE, idx, val);
    endfunction

    function automatic void add_drain();
        add_act(ACT_DRAIN, '0, '0);
    endfunction

    // noise / variance values, weighted toward small and extreme ones
    function automatic logic [DATA_W-1:0] rand_noise();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'($urandom_range(0, 16));
            3, 4:    return DATA_W'($urandom_range(0, 1 << 18));
            5:       return DATA_W'($urandom_range(1 << 18, 1 << 24));
            6:       return DATA_W'($urandom_range(1 << 24, 32'hFFFF_FFFF));
            default: return $urandom;
        endcase
    endfunction

    // measurement: mostly near a center, some full range and extremes
    function automatic logic [DATA_W-1:0] rand_meas(logic [DATA_W-1:0] center);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom;
        if (pick == 1)
            return $urandom_range(0, 1) ? EST_POS_END : EST_NEG_END;
        return center + DATA_W'($urandom_range(0, 1 << 19)) - DATA_W'(1 << 18);
    endfunction

    // driver: config writes and measurements from the pending queue
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        stim_act_t act;
        logic      nxt_mv;
        logic      nxt_cv;
        if (!rst_n)
        begin
            cfg_ch.valid           <= 1'b0;
            cfg_ch.index           <= '0;
            cfg_ch.data            <= '0;
            meas_ch.valid          <= 1'b0;
            meas_ch.measured_value <= '0;
            quiet                  <= 1'b0;
            gap_left   = 0;
            sent_count = 0;
            q_noise    = FX_TENTH;
            r_noise    = FX_TENTH;
            var_state  = FX_ONE;
            est_state  = FX_TENTH;
        end
        else
        begin
            nxt_mv = meas_ch.valid;
            nxt_cv = cfg_ch.valid;
            if (meas_ch.valid && meas_ch.ready)
            begin
                filter_step(meas_ch.measured_value);
                sent_count++;
                nxt_mv = 1'b0;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                apply_write(cfg_ch.index, cfg_ch.data);
                nxt_cv = 1'b0;
            end
            // launch the next item once the channels are free
            if (!nxt_mv && !nxt_cv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (!quiet && $urandom_range(0, 1) == 0)
                    gap_left = $urandom_range(1, 8) - 1;
                else if (stim_q.size() > 0)
                begin
                    act = stim_q[0];
                    case (act.kind)
                        ACT_DRAIN:
                        begin
                            if (taken_count == sent_count)
                                void'(stim_q.pop_front());
                        end
                        ACT_WRITE:
                        begin
                            void'(stim_q.pop_front());
                            cfg_ch.index <= act.index;
                            cfg_ch.data  <= act.value;
                            nxt_cv = 1'b1;
                        end
                        default:
                        begin
                            void'(stim_q.pop_front());
                            meas_ch.measured_value <= act.value;
                            nxt_mv = 1'b1;
                        end
                    endcase
                    quiet <= act.calm;
                end
            end
            meas_ch.valid <= nxt_mv;
            cfg_ch.valid  <= nxt_cv;
        end
    end

    // monitor: result stalls and comparison against predictions
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        filter_out_t got;
        filter_out_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            taken_count  <= 0;
            stall_left = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                taken_count <= taken_count + 1;
                got.est     = res_ch.filtered_estimate;
                got.gain    = res_ch.kalman_gain;
                got.err_var = res_ch.error_variance;
                if (outputs_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: est %0d gain %0d var %0d",
                                 got.est, got.gain, got.err_var);
                end
                else
                begin
                    want = outputs_due.pop_front();
                    if (got.est !== want.est || got.gain !== want.gain ||
                        got.err_var !== want.err_var)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch: expected est %0d gain %0d var %0d, got est %0d gain %0d var %0d",
                                     want.est, want.gain, want.err_var,
                                     got.est, got.gain, got.err_var);
                    end
                end
            end
            // random stall bursts, none in the calm phase
            if (quiet)
            begin
                stall_left = 0;
                res_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // run limit
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("status: fail");
        $finish;
    end

    // stimulus build, reset and end of run
    initial
    begin : run_ctrl
        logic [DATA_W-1:0] center;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = '0;
        meas_ch.valid          = 1'b0;
        meas_ch.measured_value = '0;
        res_ch.ready           = 1'b0;
        rst_n                  = 1'b0;

        // defaults after reset, extreme measurements
        add_meas('0);
        add_meas(EST_POS_END);
        add_meas(EST_NEG_END);
        add_meas(FX_ONE);
        // zero denominator: gain zero, state kept
        add_drain();
        add_write(REG_PROCESS_NOISE, '0);
        add_write(REG_MEAS_NOISE, '0);
        add_write(REG_INIT_ERROR, '0);
        add_meas($urandom);
        // variance saturation with unit gain, largest estimate swing
        add_drain();
        add_write(REG_INIT_ESTIMATE, EST_NEG_END);
        add_write(REG_INIT_ERROR, '1);
        add_write(REG_PROCESS_NOISE, '1);
        add_meas(EST_POS_END);
        add_meas(EST_NEG_END);
        // huge measurement noise: gain rounds to zero
        add_drain();
        add_write(REG_MEAS_NOISE, '1);
        add_write(REG_PROCESS_NOISE, '0);
        add_write(REG_INIT_ERROR, 32'd1);
        add_meas(EST_POS_END);
        // writes to unused indexes are ignored
        add_drain();
        add_write(CFG_IDX_W'(REG_IDX_TOP), '1);
        add_write(CFG_IDX_W'(int'(REG_INIT_ESTIMATE) + 1), '0);
        add_meas('1);
        // gain of one half, rounding of odd differences both ways
        add_drain();
        add_write(REG_MEAS_NOISE, FX_ONE);
        add_write(REG_INIT_ERROR, FX_ONE);
        add_write(REG_INIT_ESTIMATE, '0);
        add_meas(32'd1);
        add_drain();
        add_write(REG_INIT_ERROR, FX_ONE);
        add_write(REG_INIT_ESTIMATE, '0);
        add_meas('1);
        // back to defaults, largest estimate, most negative measurement
        add_drain();
        add_write(REG_PROCESS_NOISE, FX_TENTH);
        add_write(REG_MEAS_NOISE, FX_TENTH);
        add_write(REG_INIT_ERROR, FX_ONE);
        add_write(REG_INIT_ESTIMATE, EST_POS_END);
        add_meas(EST_NEG_END);
        add_meas($urandom);

        // random phases: new settings, then a run of measurements
        for (int ph = 0; ph < PHASES; ph++)
        begin
            calm_mode = (ph == PHASES - 1);
            add_drain();
            center = $urandom;
            if ($urandom_range(0, 1))
                add_write(REG_PROCESS_NOISE, rand_noise());
            if ($urandom_range(0, 1))
                add_write(REG_MEAS_NOISE, rand_noise());
            if ($urandom_range(0, 1))
                add_write(REG_INIT_ERROR, rand_noise());
            if ($urandom_range(0, 1))
                add_write(REG_INIT_ESTIMATE, center);
            if ($urandom_range(0, 3) == 0)
                add_write(CFG_IDX_W'($urandom_range(REG_IDX_TOP,
                                                    int'(REG_INIT_ESTIMATE) + 1)),
                          $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++)
                add_meas(rand_meas(center));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // drain stimulus and results, then let the block settle
        while (stim_q.size() != 0 || meas_ch.valid || cfg_ch.valid)
            @(posedge clk);
        while (taken_count != sent_count)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
